/* hw/rtl/tfcs_pkg.sv */
package tfcs_pkg;

   localparam int MaxTmpl     = 4;
   localparam int NumTmplDef  = 2;
   localparam int ValW        = 24;
   localparam int CoefW       = 23;
   localparam int AccW        = 48;
   // |data - model| stays below 2^50, its square below 2^100.
   localparam int DiffW       = 50;
   localparam int SqW         = 100;
   // Sum of squared errors: five terms below 2^48 each.
   localparam int VarW        = 51;
   // Quotient bits needed before the final shift by 16, plus one for overflow.
   localparam int QuoW        = 65;
   localparam int QueueDepth  = 2;
   localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

   localparam logic [1:0] RegCoefA = 2'd0;
   localparam logic [1:0] RegCoefB = 2'd1;
   localparam logic [1:0] RegCoefC = 2'd2;
   localparam logic [1:0] RegCoefD = 2'd3;

   typedef struct packed {
      logic [ValW-1:0] data_value;
      logic [ValW-1:0] data_error;
      logic [ValW-1:0] tmpl_value_a;
      logic [ValW-1:0] tmpl_error_a;
      logic [ValW-1:0] tmpl_value_b;
      logic [ValW-1:0] tmpl_error_b;
      logic [ValW-1:0] tmpl_value_c;
      logic [ValW-1:0] tmpl_error_c;
      logic [ValW-1:0] tmpl_value_d;
      logic [ValW-1:0] tmpl_error_d;
      logic            last_bin;
   } req_type;

   typedef struct packed {
      logic [AccW-1:0] chi_square;
      logic            zero_variance_seen;
      logic            sum_saturated;
   } rsp_type;

   // What the front part hands to the back part for one bin.
   typedef struct packed {
      logic [DiffW-1:0] diff;
      logic [VarW-1:0]  variance;
      logic             last_bin;
   } work_type;

endpackage

/* hw/rtl/template_fit_chi_square.sv */
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  tfcs_pkg::req_type, one histogram bin
// rsp_      out        rsp_valid/rsp_stall  tfcs_pkg::rsp_type, chi-square of a pass
// csr_      in         APB-style            four 23-bit coefficients at 0x0..0xC
//
// The front part handles a bin one template per cycle on a shared multiply-add,
// and in the back part a restoring divider produces one quotient bit per cycle
// over the 100-bit squared residual. The divider sets the sustained rate: the
// back part takes a new bin only when it is idle.
// Reset is synchronous and active high; it clears the sum, the flags and the
// coefficients. A two-entry queue separates the two parts, so the front part can
// prepare the next request while the divider works, and a held result only
// stalls the back part on a last bin.
module template_fit_chi_square #(
   parameter int NumTmpl = tfcs_pkg::NumTmplDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tfcs_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tfcs_pkg::rsp_type   rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import tfcs_pkg::*;

   logic [CoefW-1:0] coef_ff [MaxTmpl];
   logic [CoefW-1:0] coef_in [MaxTmpl];
   logic             fv, fs, bv, bs;
   work_type         fd, bd;
   logic [1:0]       reg_sel;

   // Registers are word aligned; the two low address bits are ignored.
   assign reg_sel    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-CoefW){1'b0}}, coef_ff[reg_sel]};

   always_comb begin
      coef_in = coef_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_sel)
            RegCoefA: coef_in[0] = csr_pwdata[CoefW-1:0];
            RegCoefB: coef_in[1] = csr_pwdata[CoefW-1:0];
            RegCoefC: coef_in[2] = csr_pwdata[CoefW-1:0];
            RegCoefD: coef_in[3] = csr_pwdata[CoefW-1:0];
            default:  coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{default: '0};
      end else begin
         coef_ff <= coef_in;
      end
   end

   tfcs_front #(.NumTmpl(NumTmpl)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .coef(coef_ff),
      .work_valid(fv), .work_stall(fs), .work_data(fd)
   );

   tfcs_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fv), .in_stall(fs), .in_data(fd),
      .out_valid(bv), .out_stall(bs), .out_data(bd)
   );

   tfcs_back u_back (
      .clock(clock), .reset(reset),
      .work_valid(bv), .work_stall(bs), .work_data(bd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

/* hw/rtl/tfcs_front.sv */
module tfcs_front #(
   parameter int NumTmpl = tfcs_pkg::NumTmplDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tfcs_pkg::req_type            req_data,
   input  logic [tfcs_pkg::CoefW-1:0]   coef [tfcs_pkg::MaxTmpl],
   output logic                         work_valid,
   input  logic                         work_stall,
   output tfcs_pkg::work_type           work_data
);
   import tfcs_pkg::*;

   // Step through templates one per cycle: one 24x24 and one 23x24 product.
   localparam int CntW = $clog2(MaxTmpl + 2);

   logic [ValW-1:0]  val_ff  [MaxTmpl];
   logic [ValW-1:0]  err_ff  [MaxTmpl];
   logic [ValW-1:0]  val_in  [MaxTmpl];
   logic [ValW-1:0]  err_in  [MaxTmpl];
   logic [ValW-1:0]  data_ff, data_in;
   logic             last_ff, last_in;
   logic [CntW-1:0]  step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DiffW+1:0] model_ff, model_in;
   logic [VarW-1:0]  var_ff, var_in;
   logic [DiffW+1:0] scaled;
   logic [DiffW+1:0] delta;
   logic [1:0]       idx;

   assign req_stall = busy_ff | done_ff;
   assign idx       = step_ff[1:0];
   assign scaled    = {{(DiffW+2-ValW-16){1'b0}}, data_ff, 16'd0};
   assign delta     = (scaled >= model_ff) ? scaled - model_ff : model_ff - scaled;

   assign work_valid         = done_ff;
   assign work_data.diff     = delta[DiffW-1:0];
   assign work_data.variance = var_ff;
   assign work_data.last_bin = last_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      model_in = model_ff;
      var_in   = var_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      val_in   = val_ff;
      err_in   = err_ff;
      if (done_ff && !work_stall) begin
         done_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         busy_in   = 1'b1;
         step_in   = '0;
         data_in   = req_data.data_value;
         last_in   = req_data.last_bin;
         model_in  = '0;
         var_in    = VarW'(req_data.data_error * req_data.data_error);
         val_in[0] = req_data.tmpl_value_a;
         err_in[0] = req_data.tmpl_error_a;
         val_in[1] = req_data.tmpl_value_b;
         err_in[1] = req_data.tmpl_error_b;
         val_in[2] = req_data.tmpl_value_c;
         err_in[2] = req_data.tmpl_error_c;
         val_in[3] = req_data.tmpl_value_d;
         err_in[3] = req_data.tmpl_error_d;
      end else if (busy_ff) begin
         model_in = model_ff + (DiffW+2)'(coef[idx] * val_ff[idx]);
         var_in   = var_ff + VarW'(err_ff[idx] * err_ff[idx]);
         step_in  = step_ff + 1'b1;
         if (step_ff == CntW'(NumTmpl - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      model_ff <= model_in;
      var_ff   <= var_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
      val_ff   <= val_in;
      err_ff   <= err_in;
   end

endmodule

/* hw/rtl/tfcs_queue.sv */
module tfcs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  tfcs_pkg::work_type    in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output tfcs_pkg::work_type    out_data
);
   import tfcs_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   work_type        mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign in_stall  = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

/* hw/rtl/tfcs_back.sv */
module tfcs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  work_valid,
   output logic                  work_stall,
   input  tfcs_pkg::work_type    work_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tfcs_pkg::rsp_type     rsp_data
);
   import tfcs_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StSq0  = 3'd1;
   localparam logic [2:0] StSq1  = 3'd2;
   localparam logic [2:0] StDiv  = 3'd3;
   localparam logic [2:0] StAcc  = 3'd4;
   localparam int BitW = $clog2(SqW);

   logic [2:0]       state_ff, state_in;
   logic [DiffW-1:0] diff_ff, diff_in;
   logic [VarW-1:0]  den_ff, den_in;
   logic             last_ff, last_in;
   logic [SqW-1:0]   num_ff, num_in;
   logic [VarW:0]    rem_ff, rem_in;
   logic [QuoW-1:0]  quo_ff, quo_in;
   logic             over_ff, over_in;
   logic [BitW-1:0]  bit_ff, bit_in;
   logic [AccW-1:0]  acc_ff, acc_in;
   logic             zv_ff, zv_in, sat_ff, sat_in;
   rsp_type          out_ff, out_in;
   logic             outv_ff, outv_in;
   logic [VarW+1:0]  trial;
   logic [AccW:0]    sum;
   logic [AccW-1:0]  acc_new;
   logic [2*DiffW-1:0] pp;

   assign work_stall = (state_ff != StIdle);
   assign rsp_valid  = outv_ff;
   assign rsp_data   = out_ff;
   assign trial      = {rem_ff, num_ff[SqW-1]};
   assign pp         = (state_ff == StSq0)
                       ? (2*DiffW)'(diff_ff * diff_ff[24:0])
                       : (2*DiffW)'(diff_ff * diff_ff[DiffW-1:25]) << 25;
   assign sum        = {1'b0, acc_ff} + {1'b0, quo_ff[AccW+15:16]};

   always_comb begin
      state_in = state_ff;
      diff_in  = diff_ff;
      den_in   = den_ff;
      last_in  = last_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      over_in  = over_ff;
      bit_in   = bit_ff;
      acc_in   = acc_ff;
      zv_in    = zv_ff;
      sat_in   = sat_ff;
      out_in   = out_ff;
      outv_in  = outv_ff;
      acc_new  = acc_ff;
      if (outv_ff && !rsp_stall) begin
         outv_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (work_valid) begin
               diff_in  = work_data.diff;
               den_in   = work_data.variance;
               last_in  = work_data.last_bin;
               num_in   = '0;
               state_in = StSq0;
            end
         end
         StSq0: begin
            num_in   = pp;
            state_in = StSq1;
         end
         StSq1: begin
            num_in   = num_ff + pp;
            rem_in   = '0;
            quo_in   = '0;
            over_in  = 1'b0;
            bit_in   = BitW'(SqW - 1);
            state_in = StDiv;
         end
         StDiv: begin
            // Restoring division, one quotient bit per cycle.
            num_in = num_ff << 1;
            if (quo_ff[QuoW-1]) begin
               over_in = 1'b1;
            end
            if (trial >= {1'b0, den_ff}) begin
               rem_in = (VarW+1)'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[QuoW-2:0], 1'b1};
            end else begin
               rem_in = trial[VarW:0];
               quo_in = {quo_ff[QuoW-2:0], 1'b0};
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = StAcc;
            end
         end
         StAcc: begin
            if (!outv_ff || !rsp_stall || !last_ff) begin
               if (den_ff == '0) begin
                  zv_in = 1'b1;
               end else begin
                  if (over_ff || quo_ff[QuoW-1] || sum[AccW]) begin
                     acc_new = AccMax;
                  end else begin
                     acc_new = sum[AccW-1:0];
                  end
                  acc_in = acc_new;
                  if (acc_new == AccMax) begin
                     sat_in = 1'b1;
                  end
               end
               if (last_ff) begin
                  out_in.chi_square         = acc_in;
                  out_in.zero_variance_seen = zv_in;
                  out_in.sum_saturated      = sat_in;
                  outv_in = 1'b1;
                  acc_in  = '0;
                  zv_in   = 1'b0;
                  sat_in  = 1'b0;
               end
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         acc_ff   <= '0;
         zv_ff    <= 1'b0;
         sat_ff   <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         zv_ff    <= zv_in;
         sat_ff   <= sat_in;
         outv_ff  <= outv_in;
      end
      diff_ff <= diff_in;
      den_ff  <= den_in;
      last_ff <= last_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      over_ff <= over_in;
      bit_ff  <= bit_in;
      out_ff  <= out_in;
   end

endmodule

/* hw/rtl/tfcs_checker.sv */
module tfcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [49:0] rsp_data,
   input logic        csr_pready
);
   // Result held while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // After reset no result is pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted request cannot be followed by another in the next cycle.
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("front part took two requests back to back");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready dropped");
endmodule

bind template_fit_chi_square tfcs_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data), .csr_pready(csr_pready)
);
